// ----- rtl/core/tpi_pkg.sv -----
// Shared constants for the three-plane intersection block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tpi_pkg;
    localparam int OUT_WIDTH = 32;
    localparam int DIV_STEPS = 32;
endpackage
`default_nettype wire

// ----- rtl/core/tpi_if.sv -----
// Plane-triple input channel and point output channel.
// Depends on tpi_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface tpi_in_if #(parameter int COEF_WIDTH = 16);
    logic valid;
    logic ready;
    logic signed [COEF_WIDTH-1:0] plane0_a;
    logic signed [COEF_WIDTH-1:0] plane0_b;
    logic signed [COEF_WIDTH-1:0] plane0_c;
    logic signed [COEF_WIDTH-1:0] plane0_d;
    logic signed [COEF_WIDTH-1:0] plane1_a;
    logic signed [COEF_WIDTH-1:0] plane1_b;
    logic signed [COEF_WIDTH-1:0] plane1_c;
    logic signed [COEF_WIDTH-1:0] plane1_d;
    logic signed [COEF_WIDTH-1:0] plane2_a;
    logic signed [COEF_WIDTH-1:0] plane2_b;
    logic signed [COEF_WIDTH-1:0] plane2_c;
    logic signed [COEF_WIDTH-1:0] plane2_d;
    modport source (output valid, plane0_a, plane0_b, plane0_c, plane0_d,
                    plane1_a, plane1_b, plane1_c, plane1_d,
                    plane2_a, plane2_b, plane2_c, plane2_d, input ready);
    modport sink (input valid, plane0_a, plane0_b, plane0_c, plane0_d,
                  plane1_a, plane1_b, plane1_c, plane1_d,
                  plane2_a, plane2_b, plane2_c, plane2_d, output ready);
endinterface

interface tpi_out_if;
    logic valid;
    logic ready;
    logic signed [tpi_pkg::OUT_WIDTH-1:0] point_x;
    logic signed [tpi_pkg::OUT_WIDTH-1:0] point_y;
    logic signed [tpi_pkg::OUT_WIDTH-1:0] point_z;
    logic solved;
    logic saturated;
    modport source (output valid, point_x, point_y, point_z, solved, saturated,
                    input ready);
    modport sink (input valid, point_x, point_y, point_z, solved, saturated,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/core/three_plane_intersection.sv -----
// Three-plane intersection by Cramer's rule, fully pipelined.
// Depends on tpi_pkg and the channel interfaces in tpi_if.
`timescale 1ns / 1ps
`default_nettype none
// Takes one plane triple per cycle and returns one point per word, in order,
// through DIV_STEPS + 8 register stages (40 by default).
// Front stages form the exact determinants (products, 2x2 minors, products,
// sums, magnitudes);
// one restoring-division stage per quotient bit then resolves the three
// coordinates side by side. The whole pipe stalls together when the output
// register holds a word that is not taken; otherwise it runs every cycle.
module three_plane_intersection #(
    parameter int COEF_WIDTH    = 16,
    parameter int OUT_FRAC_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tpi_in_if.sink    planes,
    tpi_out_if.source result
);
    localparam int QW   = tpi_pkg::OUT_WIDTH;
    localparam int NS   = tpi_pkg::DIV_STEPS;
    localparam int EW   = COEF_WIDTH + 1;
    localparam int PW   = 2 * EW;
    localparam int MW   = PW + 1;
    localparam int TW   = EW + MW;
    localparam int DW   = 3 * EW + 3;
    localparam int NW   = DW + OUT_FRAC_BITS + QW;
    localparam int TPW  = DW + OUT_FRAC_BITS;
    localparam int NSTG = 8 + NS;

    localparam int PU [6] = '{0, 0, 0, 1, 1, 2};
    localparam int PV [6] = '{1, 2, 3, 2, 3, 3};
    localparam int CI [4][3] = '{'{0, 1, 2}, '{3, 1, 2}, '{0, 3, 2}, '{0, 1, 3}};
    localparam int MI [4][3] = '{'{3, 1, 0}, '{3, 5, 4}, '{5, 1, 2}, '{4, 2, 0}};
    localparam bit NG [4][3] = '{'{1'b0, 1'b1, 1'b0}, '{1'b0, 1'b0, 1'b1},
                                 '{1'b1, 1'b1, 1'b0}, '{1'b0, 1'b1, 1'b0}};

    logic adv;
    logic [NSTG-1:0] vld_reg;

    logic signed [COEF_WIDTH-1:0] raw [3][4];
    logic signed [EW-1:0] e_reg [3][4];
    logic signed [PW-1:0] p_reg [6][2];
    logic signed [EW-1:0] r2_reg [4];
    logic signed [MW-1:0] m_reg [6];
    logic signed [EW-1:0] r3_reg [4];
    logic signed [TW-1:0] t_reg [4][3];
    logic signed [DW-1:0] dt_reg [4];
    logic [DW-1:0] mag_reg [4];
    logic sgn_reg [4];
    logic slv6_reg;

    logic [DW-1:0]  rem_reg [NS+1][3];
    logic [QW-1:0]  lo_reg  [NS+1][3];
    logic [QW-1:0]  q_reg   [NS+1][3];
    logic           ovf_reg [NS+1][3];
    logic           neg_reg [NS+1][3];
    logic [DW-1:0]  dv_reg  [NS+1];
    logic           slv_reg [NS+1];

    logic [QW-1:0] px_reg, py_reg, pz_reg;
    logic          solved_reg, sat_reg;
    logic [QW-1:0] pt_next [3];
    logic          sat_next;

    assign adv          = !vld_reg[NSTG-1] || result.ready;
    assign planes.ready = adv;

    assign raw[0][0] = planes.plane0_a;
    assign raw[0][1] = planes.plane0_b;
    assign raw[0][2] = planes.plane0_c;
    assign raw[0][3] = planes.plane0_d;
    assign raw[1][0] = planes.plane1_a;
    assign raw[1][1] = planes.plane1_b;
    assign raw[1][2] = planes.plane1_c;
    assign raw[1][3] = planes.plane1_d;
    assign raw[2][0] = planes.plane2_a;
    assign raw[2][1] = planes.plane2_b;
    assign raw[2][2] = planes.plane2_c;
    assign raw[2][3] = planes.plane2_d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], planes.valid};
        end
    end

    // Front: load, products, minors, products, sums, magnitudes.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    e_reg[r][c] <= EW'(raw[r][c]);
                end
                e_reg[r][3] <= -EW'(raw[r][3]);
            end
            for (int k = 0; k < 6; k++)
            begin
                p_reg[k][0] <= e_reg[1][PU[k]] * e_reg[2][PV[k]];
                p_reg[k][1] <= e_reg[1][PV[k]] * e_reg[2][PU[k]];
                m_reg[k]    <= MW'(p_reg[k][0]) - MW'(p_reg[k][1]);
            end
            for (int c = 0; c < 4; c++)
            begin
                r2_reg[c] <= e_reg[0][c];
                r3_reg[c] <= r2_reg[c];
            end
            for (int k = 0; k < 4; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    t_reg[k][j] <= TW'(r3_reg[CI[k][j]]) * TW'(m_reg[MI[k][j]]);
                end
                dt_reg[k] <= (NG[k][0] ? -DW'(t_reg[k][0]) : DW'(t_reg[k][0]))
                           + (NG[k][1] ? -DW'(t_reg[k][1]) : DW'(t_reg[k][1]))
                           + (NG[k][2] ? -DW'(t_reg[k][2]) : DW'(t_reg[k][2]));
                sgn_reg[k] <= dt_reg[k][DW-1];
                mag_reg[k] <= dt_reg[k][DW-1] ? DW'(-dt_reg[k]) : DW'(dt_reg[k]);
            end
            slv6_reg <= (dt_reg[0] != '0);
        end
    end

    // Divider setup: scale numerators, detect quotients of 2^32 or more.
    always_ff @(posedge clk)
    begin : div_init
        logic [NW-1:0] n;
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                n = NW'(mag_reg[k+1]) << OUT_FRAC_BITS;
                ovf_reg[0][k] <= (n[NW-1:QW] >= TPW'(mag_reg[0]));
                rem_reg[0][k] <= n[DW+QW-1:QW];
                lo_reg[0][k]  <= n[QW-1:0];
                q_reg[0][k]   <= '0;
                neg_reg[0][k] <= sgn_reg[k+1] ^ sgn_reg[0];
            end
            dv_reg[0]  <= mag_reg[0];
            slv_reg[0] <= slv6_reg;
        end
    end

    for (genvar s = 0; s < NS; s++)
    begin : g_div
        always_ff @(posedge clk)
        begin : step
            logic [DW:0] trial;
            logic [DW:0] diff;
            if (adv)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    trial = {rem_reg[s][k], lo_reg[s][k][QW-1]};
                    diff  = trial - {1'b0, dv_reg[s]};
                    rem_reg[s+1][k] <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
                    q_reg[s+1][k]   <= {q_reg[s][k][QW-2:0], !diff[DW]};
                    lo_reg[s+1][k]  <= lo_reg[s][k] << 1;
                    ovf_reg[s+1][k] <= ovf_reg[s][k];
                    neg_reg[s+1][k] <= neg_reg[s][k];
                end
                dv_reg[s+1]  <= dv_reg[s];
                slv_reg[s+1] <= slv_reg[s];
            end
        end
    end

    // Zero unsolved points, saturate and apply sign.
    always_comb
    begin
        sat_next = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            if (!slv_reg[NS])
            begin
                pt_next[k] = '0;
            end
            else if (!neg_reg[NS][k])
            begin
                if (ovf_reg[NS][k] || q_reg[NS][k][QW-1])
                begin
                    pt_next[k] = {1'b0, {(QW-1){1'b1}}};
                    sat_next   = 1'b1;
                end
                else
                begin
                    pt_next[k] = q_reg[NS][k];
                end
            end
            else
            begin
                if (ovf_reg[NS][k] || q_reg[NS][k] > {1'b1, {(QW-1){1'b0}}})
                begin
                    pt_next[k] = {1'b1, {(QW-1){1'b0}}};
                    sat_next   = 1'b1;
                end
                else
                begin
                    pt_next[k] = -q_reg[NS][k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg     <= pt_next[0];
            py_reg     <= pt_next[1];
            pz_reg     <= pt_next[2];
            solved_reg <= slv_reg[NS];
            sat_reg    <= sat_next;
        end
    end

    assign result.valid     = vld_reg[NSTG-1];
    assign result.point_x   = px_reg;
    assign result.point_y   = py_reg;
    assign result.point_z   = pz_reg;
    assign result.solved    = solved_reg;
    assign result.saturated = sat_reg;
endmodule
`default_nettype wire

// ----- test/three_plane_intersection_test.sv -----
// Self-checking testbench for three_plane_intersection: Cramer's rule point solver.
// Depends on tpi_pkg and the tpi_in_if / tpi_out_if channels from the RTL.
`timescale 1ns / 1ps
module three_plane_intersection_test;
    localparam int COEF_W    = 16;
    localparam int FRAC_BITS = 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int RANDOM_ITEMS   = 1600;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef coef_t plane_set_t [12];
    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic signed [tpi_pkg::OUT_WIDTH-1:0] x;
        logic signed [tpi_pkg::OUT_WIDTH-1:0] y;
        logic signed [tpi_pkg::OUT_WIDTH-1:0] z;
        logic solved;
        logic saturated;
    } point_t;

    typedef struct {
        plane_set_t coefs;
        bit known;
        point_t point;
    } stim_row_t;

    logic clk;
    logic rst_n;

    tpi_in_if #(.COEF_WIDTH(COEF_W)) planes_ch ();
    tpi_out_if result_ch ();

    three_plane_intersection #(.COEF_WIDTH(COEF_W), .OUT_FRAC_BITS(FRAC_BITS)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .planes (planes_ch),
        .result (result_ch)
    );

    point_t pending_points[$];
    stim_row_t stim_table[$];
    int fail_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic wide_t det3(wide_t m [9]);
        wide_t m0, m1, m2;
        m0 = m[4] * m[8] - m[5] * m[7];
        m1 = m[3] * m[8] - m[5] * m[6];
        m2 = m[3] * m[7] - m[4] * m[6];
        return m[0] * m0 - m[1] * m1 + m[2] * m2;
    endfunction

    function automatic point_t solve_planes(plane_set_t p);
        wide_t m [9];
        wide_t a [9];
        wide_t neg_d [3];
        wide_t det, adet, dk, mag, quot;
        logic signed [tpi_pkg::OUT_WIDTH-1:0] coord [3];
        logic sat;
        logic neg;
        point_t res;
        sat = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
                m[r * 3 + c] = wide_t'(p[r * 4 + c]);
            neg_d[r] = -wide_t'(p[r * 4 + 3]);
        end
        det = det3(m);
        res = '0;
        if (det == 0)
            return res;
        adet = (det < 0) ? -det : det;
        for (int k = 0; k < 3; k++)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    a[r * 3 + c] = (c == k) ? neg_d[r] : m[r * 3 + c];
            dk = det3(a);
            mag = (dk < 0) ? -dk : dk;
            quot = wide_t'(unsigned'(mag << FRAC_BITS) / unsigned'(adet));
            neg = (dk < 0) != (det < 0);
            if (!neg)
            begin
                if (quot > 128'sh7FFF_FFFF)
                begin
                    coord[k] = 32'sh7FFF_FFFF;
                    sat = 1'b1;
                end
                else
                    coord[k] = quot[31:0];
            end
            else
            begin
                if (quot > 128'sh8000_0000)
                begin
                    coord[k] = 32'sh8000_0000;
                    sat = 1'b1;
                end
                else
                    coord[k] = -quot[31:0];
            end
        end
        res.x = coord[0];
        res.y = coord[1];
        res.z = coord[2];
        res.solved = 1'b1;
        res.saturated = sat;
        return res;
    endfunction

    function automatic coef_t pick_coef(int mode);
        int sel;
        case (mode)
            0: return coef_t'($urandom);
            1: return coef_t'($urandom_range(8) - 4);
            default:
            begin
                sel = $urandom_range(4);
                case (sel)
                    0: return -16'sd32768;
                    1: return 16'sd32767;
                    2: return -16'sd1;
                    3: return 16'sd1;
                    default: return 16'sd0;
                endcase
            end
        endcase
    endfunction

    function automatic plane_set_t random_planes();
        plane_set_t p;
        int mode;
        mode = $urandom_range(9);
        for (int i = 0; i < 12; i++)
            case (mode)
                0, 1, 2, 3: p[i] = pick_coef(0);
                4, 5: p[i] = pick_coef(1);
                6: p[i] = pick_coef(2);
                default: p[i] = pick_coef(0);
            endcase
        case (mode)
            7:
                for (int i = 0; i < 4; i++)
                    p[8 + i] = p[i];
            8:
                for (int r = 0; r < 3; r++)
                begin
                    for (int c = 0; c < 3; c++)
                        p[r * 4 + c] = coef_t'($urandom_range(512) - 256);
                    p[r * 5] = coef_t'($urandom_range(8192) + 1024);
                end
            9:
                for (int r = 0; r < 3; r++)
                    p[r * 4 + 3] = pick_coef(1);
            default: ;
        endcase
        return p;
    endfunction

    task automatic add_row(plane_set_t p, bit known, point_t pt);
        stim_row_t row;
        row.coefs = p;
        row.known = known;
        row.point = pt;
        stim_table.push_back(row);
    endtask

    task automatic put_word(plane_set_t p);
        planes_ch.plane0_a = p[0];
        planes_ch.plane0_b = p[1];
        planes_ch.plane0_c = p[2];
        planes_ch.plane0_d = p[3];
        planes_ch.plane1_a = p[4];
        planes_ch.plane1_b = p[5];
        planes_ch.plane1_c = p[6];
        planes_ch.plane1_d = p[7];
        planes_ch.plane2_a = p[8];
        planes_ch.plane2_b = p[9];
        planes_ch.plane2_c = p[10];
        planes_ch.plane2_d = p[11];
    endtask

    // Hold the word until taken, then queue its point.
    task automatic send_word(plane_set_t p, point_t pt);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            planes_ch.valid = 1'b0;
            @(negedge clk);
        end
        put_word(p);
        planes_ch.valid = 1'b1;
        forever
        begin
            @(posedge clk);
            if (planes_ch.ready)
                break;
        end
        pending_points.push_back(pt);
    endtask

    task automatic wait_drained();
        while (pending_points.size() != 0)
            @(posedge clk);
    endtask

    always @(negedge clk)
        if (rst_n)
            result_ch.ready = ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        point_t want;
        if (rst_n)
        begin
            if ((planes_ch.valid && planes_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("three_plane_intersection_test NOT OK");
                $finish;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (pending_points.size() == 0)
                begin
                    $error("unexpected point word");
                    fail_count++;
                end
                else
                begin
                    want = pending_points.pop_front();
                    if (result_ch.point_x !== want.x)
                    begin
                        $error("point_x expected %h got %h", want.x, result_ch.point_x);
                        fail_count++;
                    end
                    if (result_ch.point_y !== want.y)
                    begin
                        $error("point_y expected %h got %h", want.y, result_ch.point_y);
                        fail_count++;
                    end
                    if (result_ch.point_z !== want.z)
                    begin
                        $error("point_z expected %h got %h", want.z, result_ch.point_z);
                        fail_count++;
                    end
                    if (result_ch.solved !== want.solved)
                    begin
                        $error("solved expected %b got %b", want.solved, result_ch.solved);
                        fail_count++;
                    end
                    if (result_ch.saturated !== want.saturated)
                    begin
                        $error("saturated expected %b got %b", want.saturated,
                               result_ch.saturated);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        plane_set_t zero_set;
        plane_set_t p;
        point_t pt;
        point_t none;
        none = '0;
        foreach (zero_set[i])
            zero_set[i] = '0;
        rst_n = 1'b0;
        planes_ch.valid = 1'b0;
        put_word(zero_set);
        result_ch.ready = 1'b0;

        add_row('{256, 0, 0, 0, 0, 256, 0, 0, 0, 0, 256, 0}, 1,
                '{32'sh0, 32'sh0, 32'sh0, 1'b1, 1'b0});
        add_row(zero_set, 1, none);
        add_row('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                  -32768, -32768, -32768, -32768}, 1, none);
        add_row('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                  32767, 32767, 32767, 32767}, 1, none);
        add_row('{256, 0, 0, -256, 0, 256, 0, -512, 0, 0, 256, -768}, 1,
                '{32'sh10000, 32'sh20000, 32'sh30000, 1'b1, 1'b0});
        add_row('{1, 0, 0, -32768, 0, 1, 0, -32768, 0, 0, 1, -32768}, 1,
                '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 1'b1});
        add_row('{-1, 0, 0, -32768, 0, -1, 0, -32768, 0, 0, -1, -32768}, 1,
                '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1, 1'b0});
        add_row('{1, 0, 0, 32767, 0, 1, 0, 32767, 0, 0, 1, 32767}, 1,
                '{32'sh8001_0000, 32'sh8001_0000, 32'sh8001_0000, 1'b1, 1'b0});
        add_row('{32767, 0, 0, 1, 0, 32767, 0, 1, 0, 0, 32767, 1}, 1,
                '{32'shFFFF_FFFE, 32'shFFFF_FFFE, 32'shFFFF_FFFE, 1'b1, 1'b0});
        add_row('{-32768, 0, 0, 32767, 0, -32768, 0, 32767, 0, 0, -32768, 32767}, 1,
                '{32'sh0000_FFFE, 32'sh0000_FFFE, 32'sh0000_FFFE, 1'b1, 1'b0});
        add_row('{300, -20, 7, 100, 300, -20, 7, -55, 12, 9, -400, 3}, 1, none);
        add_row('{1, 0, 0, -32768, 0, 1, 0, 32767, 0, 0, 32767, -32768}, 0, none);
        add_row('{-32768, 32767, 1, 5, 32767, -32768, -1, -5, 7, 3, 2, 1}, 0, none);
        add_row('{32767, 32767, 0, -32768, 32767, -32767, 0, 32767, 0, 0, 1, 0}, 0, none);
        add_row('{1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 12, 11}, 0, none);
        add_row('{-1, -1, -1, -1, -2, 1, -1, 0, 1, 1, -2, 1}, 0, none);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        result_ch.ready = 1'b1;

        foreach (stim_table[i])
        begin
            pt = stim_table[i].known ? stim_table[i].point : solve_planes(stim_table[i].coefs);
            send_word(stim_table[i].coefs, pt);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 84 : 0;
            recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 23 : 0;
            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
            begin
                p = random_planes();
                send_word(p, solve_planes(p));
            end
            @(negedge clk);
            planes_ch.valid = 1'b0;
            wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("three_plane_intersection_test OK");
        else
            $display("three_plane_intersection_test NOT OK");
        $finish;
    end
endmodule
